@@ hdl/rha_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Handle allocator package
// Shared codes, field widths, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rha_pkg;

   localparam int HANDLE_W = 7;
   localparam int STATUS_W = 3;
   localparam int REFCNT_W = 16;
   localparam int OP_W     = 2;

   localparam int DEF_TABLE_SIZE  = 128;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_DROP  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD      = 3'd4;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_LOOKUP = 6'b000100,
      S_EVAL   = 6'b001000,
      S_SCAN   = 6'b010000,
      S_RESP   = 6'b100000
   } rha_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic evaluate;
      logic scan;
      logic load_out;
   } rha_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_scan;
      logic scan_done;
      logic out_free;
   } rha_sts_type;

endpackage
`default_nettype wire

@@ hdl/rha_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Handle allocator controller
// Sequences the clearing pass, table lookup, evaluation, hole scan and reply.
// ----------------------------------------------------------------------------
module rha_ctrl
   import rha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire rha_sts_type sts,
   output rha_cmd_type      cmd
);

   rha_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            cmd.evaluate = 1'b1;
            state_in     = sts.need_scan ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/rha_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Handle allocator datapath
// Count table memory, allocation marks, hole scan pointer and result registers.
// ----------------------------------------------------------------------------
module rha_dp
   import rha_pkg::*;
#(
   parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rha_cmd_type           cmd,
   output rha_sts_type                sts,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [HANDLE_W-1:0]   req_handle,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic [HANDLE_W-1:0]        rsp_result_handle,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [REFCNT_W-1:0]        rsp_ref_count
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int MARK_W = $clog2(TABLE_SIZE + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   logic [COUNT_WIDTH-1:0] mem [TABLE_SIZE];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]       rd_addr, wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   wr_en;

   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [HANDLE_W-1:0] hdl_ff, hdl_in;
   logic [MARK_W-1:0]   ff_ff, ff_in;
   logic [MARK_W-1:0]   end_ff, end_in;
   logic [MARK_W-1:0]   hc_ff, hc_in;
   logic [MARK_W-1:0]   scan_ff, scan_in;
   logic [HANDLE_W-1:0] res_h_ff, res_h_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic [REFCNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_h_ff;
   logic [STATUS_W-1:0] rsp_st_ff;
   logic [REFCNT_W-1:0] rsp_cnt_ff;

   logic [IDX_W-1:0]       h_idx;
   logic [MARK_W-1:0]      h_mark, h_next, ff_next, scan_next;
   logic                   h_bad, ff_ok;
   logic [COUNT_WIDTH-1:0] cnt_dec;

   assign h_idx     = IDX_W'(hdl_ff);
   assign h_mark    = MARK_W'(hdl_ff);
   assign h_next    = h_mark + MARK_W'(1);
   assign ff_next   = ff_ff + MARK_W'(1);
   assign scan_next = scan_ff + MARK_W'(1);
   assign cnt_dec   = rd_data_ff - COUNT_WIDTH'(1);
   assign h_bad     = (op_ff != OP_ADD && op_ff != OP_DROP) || (hdl_ff == '0) ||
                      (32'(hdl_ff) >= 32'(TABLE_SIZE));
   assign ff_ok     = (ff_ff != '0) && (32'(ff_ff) < 32'(TABLE_SIZE));

   always_comb begin
      ff_in      = ff_ff;
      end_in     = end_ff;
      hc_in      = hc_ff;
      scan_in    = scan_ff;
      res_h_in   = res_h_ff;
      res_st_in  = res_st_ff;
      res_cnt_in = res_cnt_ff;
      clr_in     = clr_ff;
      op_in      = op_ff;
      hdl_in     = hdl_ff;
      wr_en      = 1'b0;
      wr_addr    = clr_ff;
      wr_data    = '0;
      rd_addr    = h_idx;
      sts        = '0;

      sts.clear_last = (clr_ff == LAST_IDX);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;

      if (cmd.clear) begin
         wr_en  = 1'b1;
         clr_in = clr_ff + IDX_W'(1);
      end

      if (cmd.capture) begin
         op_in  = req_operation;
         hdl_in = req_handle;
      end

      if (cmd.lookup) begin
         rd_addr = (op_ff == OP_ALLOC) ? IDX_W'(ff_ff) : h_idx;
      end

      if (cmd.evaluate) begin
         if (op_ff == OP_ALLOC) begin
            res_h_in   = '0;
            res_st_in  = ST_FULL;
            res_cnt_in = '0;
            if (hc_ff != '0) begin
               if (ff_ok && rd_data_ff == '0) begin
                  wr_en      = 1'b1;
                  wr_addr    = IDX_W'(ff_ff);
                  wr_data    = COUNT_WIDTH'(1);
                  hc_in      = hc_ff - MARK_W'(1);
                  res_h_in   = HANDLE_W'(ff_ff);
                  res_st_in  = ST_OK;
                  res_cnt_in = REFCNT_W'(1);
                  if (hc_ff != MARK_W'(1)) begin
                     sts.need_scan = 1'b1;
                     scan_in       = ff_next;
                     rd_addr       = IDX_W'(ff_next);
                  end else begin
                     ff_in = end_ff;
                  end
               end
            end else if (ff_ok) begin
               wr_en      = 1'b1;
               wr_addr    = IDX_W'(ff_ff);
               wr_data    = COUNT_WIDTH'(1);
               end_in     = ff_next;
               ff_in      = ff_next;
               res_h_in   = HANDLE_W'(ff_ff);
               res_st_in  = ST_OK;
               res_cnt_in = REFCNT_W'(1);
            end
         end else begin
            res_h_in   = hdl_ff;
            res_cnt_in = '0;
            if (h_bad) begin
               res_st_in = ST_BAD;
            end else if (rd_data_ff == '0) begin
               res_st_in = ST_FREE;
            end else if (op_ff == OP_ADD) begin
               wr_en      = 1'b1;
               wr_addr    = h_idx;
               wr_data    = (rd_data_ff == COUNT_MAX) ? rd_data_ff :
                            rd_data_ff + COUNT_WIDTH'(1);
               res_st_in  = ST_OK;
               res_cnt_in = REFCNT_W'(wr_data);
            end else begin
               wr_en   = 1'b1;
               wr_addr = h_idx;
               wr_data = cnt_dec;
               if (cnt_dec != '0) begin
                  res_st_in  = ST_OK;
                  res_cnt_in = REFCNT_W'(cnt_dec);
               end else begin
                  res_st_in = ST_RELEASED;
                  if (ff_ff > h_mark) begin
                     ff_in = h_mark;
                     if (end_ff == h_next) begin
                        end_in = h_mark;
                     end else begin
                        hc_in = hc_ff + MARK_W'(1);
                     end
                  end else if (end_ff == h_next) begin
                     end_in = h_mark;
                  end else begin
                     hc_in = hc_ff + MARK_W'(1);
                  end
               end
            end
         end
      end

      if (cmd.scan) begin
         if (scan_ff >= end_ff) begin
            ff_in         = end_ff;
            sts.scan_done = 1'b1;
         end else if (rd_data_ff == '0) begin
            ff_in         = scan_ff;
            sts.scan_done = 1'b1;
         end else begin
            scan_in = scan_next;
            rd_addr = IDX_W'(scan_next);
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         ff_ff        <= MARK_W'(1);
         end_ff       <= MARK_W'(1);
         hc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         ff_ff        <= ff_in;
         end_ff       <= end_in;
         hc_ff        <= hc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      hdl_ff     <= hdl_in;
      scan_ff    <= scan_in;
      res_h_ff   <= res_h_in;
      res_st_ff  <= res_st_in;
      res_cnt_ff <= res_cnt_in;
      if (cmd.load_out) begin
         rsp_h_ff   <= res_h_ff;
         rsp_st_ff  <= res_st_ff;
         rsp_cnt_ff <= res_cnt_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = rsp_h_ff;
   assign rsp_status        = rsp_st_ff;
   assign rsp_ref_count     = rsp_cnt_ff;

`ifndef SYNTH
   a_first_free_le_end: assert property (@(posedge clock) disable iff (reset)
      ff_ff <= end_ff)
      else $error("First-free mark lies beyond the end mark.");

   a_scan_within_end: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> scan_ff <= end_ff)
      else $error("Hole scan pointer passed the end mark.");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("Loaded result item is not presented.");

   a_no_load_while_held: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Result item overwritten before it was taken.");
`endif

endmodule
`default_nettype wire

@@ hdl/refcounted_handle_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Reference-counted handle allocator
// Allocates handles, adds and drops references on a table of counts.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count table, one entry
// per cycle, with req_stall held high. Each item then passes through the
// states in order: the accepting cycle in S_IDLE, which captures it, the table
// read in S_LOOKUP, evaluation and update in S_EVAL, and S_RESP, at whose end
// the result is loaded once the output register is free. An allocation
// that reuses a hole while other holes remain scans the table upward for the
// next hole through the single memory read port, examining one entry after
// another, at most up to the end mark. A finished result waits in its own
// output register, so the next item can be accepted while it is still stalled.
module refcounted_handle_allocator_top
   import rha_pkg::*;
#(
   parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [HANDLE_W-1:0] req_handle,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [HANDLE_W-1:0]      rsp_result_handle,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [REFCNT_W-1:0]      rsp_ref_count
);

   rha_cmd_type cmd;
   rha_sts_type sts;

   rha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rha_dp #(
      .TABLE_SIZE  (TABLE_SIZE),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_handle        (req_handle),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_result_handle (rsp_result_handle),
      .rsp_status        (rsp_status),
      .rsp_ref_count     (rsp_ref_count)
   );

endmodule
`default_nettype wire
